FILE: design/hsvc_pkg.sv
// Shared types and constants for the HSV/RGB pixel converter.
`timescale 1ns / 1ps

package hsvc_pkg;

  // One full turn of hue in 1/1536 steps
  localparam logic [10:0] HueTurn = 11'd1536;

  // Cycles from an accepted start to its done strobe
  localparam int PipeLatency = 12;

  // Reciprocal of 255 for a 16-bit dividend: q = (n * RecipMul) >> RecipShift
  localparam logic [31:0] RecipMul   = 32'h0000_8081;
  localparam int          RecipShift = 23;

  // Channel that holds the maximum; it also selects the hue offset
  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } hsvc_sel_t;

  // Per-beat control and payload that rides beside the dividers
  typedef struct packed {
    logic       func;
    logic [7:0] alpha;
    logic       grey;
    logic       neg;
    hsvc_sel_t  sel;
    logic [7:0] vmax;
  } hsvc_side_t;

  // RGB result of the HSV to RGB path
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvc_rgb_t;

endpackage

FILE: design/hsv_rgb_color_convert_top.sv
// Top level of the HSV/RGB pixel converter pipeline.
`timescale 1ns / 1ps

// Converts one pixel per clock between HSV and RGB, direction chosen by func.
// busy is always low: a pixel may be started in every cycle. Each started
// pixel comes out with a one-cycle done strobe, in start order; the receiver
// cannot stall. The latency is set by the two nine-stage divider pipelines
// (hue fraction and saturation) of the RGB to HSV path, which the HSV to RGB
// results wait on.
// Unused result fields of each direction read as zero; alpha passes through.
module hsv_rgb_color_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [10:0] hue_in,
  input  logic [7:0]  sat_in,
  input  logic [7:0]  val_in,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [10:0] hue_out,
  output logic [7:0]  sat_out,
  output logic [7:0]  val_out,
  output logic [7:0]  alpha_out
);

  import hsvc_pkg::*;

  localparam int SideDepth = 10;
  localparam int RgbDepth  = 8;

  // Stage 1 registers
  logic        s1_valid;
  logic        s1_func;
  logic [10:0] s1_hue;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_val;
  logic [7:0]  s1_red;
  logic [7:0]  s1_grn;
  logic [7:0]  s1_blu;
  logic [7:0]  s1_alpha;

  // Stage 2 registers
  logic        s2_valid;
  logic        s2_func;
  logic [7:0]  s2_alpha;
  logic [10:0] s2_hue;
  logic [7:0]  s2_val;
  logic [15:0] s2_vs;
  logic [7:0]  s2_mx;
  logic [7:0]  s2_d;
  hsvc_sel_t   s2_sel;
  logic        s2_neg;
  logic [7:0]  s2_adiff;

  // Stage 3 registers
  logic [10:0] s3_hue;
  logic [7:0]  s3_val;
  logic [7:0]  s3_c;
  logic [16:0] s3_hnum;
  logic [16:0] s3_snum;
  logic [7:0]  s3_d;
  logic [7:0]  s3_mx;

  // Stage 4 registers
  logic [15:0] s4_xprod;
  logic [7:0]  s4_c;
  logic [7:0]  s4_m;
  logic [2:0]  s4_sector;

  // Delay lines
  logic [SideDepth-1:0] side_valid;
  hsvc_side_t           side [SideDepth];
  hsvc_rgb_t            rgbd [RgbDepth];

  // Combinational values
  logic [10:0] hue_wrap;
  logic [15:0] vs_prod;
  logic        red_max;
  logic        grn_max;
  hsvc_sel_t   sel_next;
  logic [7:0]  mx_next;
  logic [7:0]  mn_next;
  logic [7:0]  pa;
  logic [7:0]  qa;
  logic [31:0] recip_prod;
  logic [16:0] hnum_next;
  logic [16:0] snum_next;
  logic [8:0]  factor;
  logic [15:0] xprod_next;
  logic [7:0]  x_val;
  hsvc_rgb_t   rgb_next;
  logic [8:0]  hue_quo;
  logic [8:0]  sat_quo;
  logic [11:0] hoff;
  logic [11:0] hsum;
  logic [11:0] hwrap;

  assign busy = 1'b0;

  // Capture a beat every cycle; valid marks a real start
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_func  <= func;
    s1_hue   <= hue_in;
    s1_sat   <= sat_in;
    s1_val   <= val_in;
    s1_red   <= red_in;
    s1_grn   <= green_in;
    s1_blu   <= blue_in;
    s1_alpha <= alpha_in;
  end

  // Wrap hue, form v*s, find max/min and the hue difference
  always_comb begin
    hue_wrap = (s1_hue >= HueTurn) ? (s1_hue - HueTurn) : s1_hue;
    vs_prod  = ({8'd0, s1_val} * {8'd0, s1_sat}) + 16'd127;
    red_max  = (s1_red >= s1_grn) && (s1_red >= s1_blu);
    grn_max  = !red_max && (s1_grn >= s1_blu);
    if (red_max) begin
      sel_next = SEL_RED;
    end else if (grn_max) begin
      sel_next = SEL_GREEN;
    end else begin
      sel_next = SEL_BLUE;
    end
    case (sel_next)
      SEL_RED: begin
        mx_next = s1_red;
        pa      = s1_grn;
        qa      = s1_blu;
      end
      SEL_GREEN: begin
        mx_next = s1_grn;
        pa      = s1_blu;
        qa      = s1_red;
      end
      default: begin
        mx_next = s1_blu;
        pa      = s1_red;
        qa      = s1_grn;
      end
    endcase
    mn_next = s1_red;
    if (s1_grn < mn_next) begin
      mn_next = s1_grn;
    end
    if (s1_blu < mn_next) begin
      mn_next = s1_blu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_func  <= s1_func;
    s2_alpha <= s1_alpha;
    s2_hue   <= hue_wrap;
    s2_val   <= s1_val;
    s2_vs    <= vs_prod;
    s2_mx    <= mx_next;
    s2_d     <= mx_next - mn_next;
    s2_sel   <= sel_next;
    s2_neg   <= (pa < qa);
    s2_adiff <= (pa < qa) ? (qa - pa) : (pa - qa);
  end

  // Chroma by reciprocal of 255; build both dividends with rounding halves
  always_comb begin
    recip_prod = {16'd0, s2_vs} * RecipMul;
    hnum_next  = {1'b0, s2_adiff, 8'd0} + {10'd0, s2_d[7:1]};
    snum_next  = {1'b0, s2_d, 8'd0} - {9'd0, s2_d} + {10'd0, s2_mx[7:1]};
  end

  always_ff @(posedge clk) begin
    s3_hue  <= s2_hue;
    s3_val  <= s2_val;
    s3_c    <= recip_prod[RecipShift +: 8];
    s3_hnum <= hnum_next;
    s3_snum <= snum_next;
    s3_d    <= s2_d;
    s3_mx   <= s2_mx;
  end

  // Hold control and pass-through fields beside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= '0;
    end else begin
      side_valid <= {side_valid[SideDepth-2:0], s2_valid};
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{func:  s2_func,
                 alpha: s2_alpha,
                 grey:  (s2_d == 8'd0),
                 neg:   s2_neg,
                 sel:   s2_sel,
                 vmax:  s2_mx};
    for (int i = 1; i < SideDepth; i++) begin
      side[i] <= side[i-1];
    end
  end

  // Hue fraction and saturation dividers
  hsvc_div #(.NUM_W(17), .DEN_W(8), .Q_W(9)) u_hue_div (
    .clk (clk),
    .num (s3_hnum),
    .den (s3_d),
    .quo (hue_quo)
  );

  hsvc_div #(.NUM_W(17), .DEN_W(8), .Q_W(9)) u_sat_div (
    .clk (clk),
    .num (s3_snum),
    .den (s3_mx),
    .quo (sat_quo)
  );

  // Scale chroma by the hue fraction, mirrored in odd sectors
  always_comb begin
    factor     = s3_hue[8] ? (9'd256 - {1'b0, s3_hue[7:0]}) : {1'b0, s3_hue[7:0]};
    xprod_next = ({8'd0, s3_c} * {7'd0, factor}) + 16'd128;
  end

  always_ff @(posedge clk) begin
    s4_xprod  <= xprod_next;
    s4_c      <= s3_c;
    s4_m      <= s3_val - s3_c;
    s4_sector <= s3_hue[10:8];
  end

  // Place chroma and x by sector, then add the offset m
  always_comb begin
    x_val = s4_xprod[15:8];
    case (s4_sector)
      3'd0:    rgb_next = '{red: s4_c,  green: x_val, blue: 8'd0};
      3'd1:    rgb_next = '{red: x_val, green: s4_c,  blue: 8'd0};
      3'd2:    rgb_next = '{red: 8'd0,  green: s4_c,  blue: x_val};
      3'd3:    rgb_next = '{red: 8'd0,  green: x_val, blue: s4_c};
      3'd4:    rgb_next = '{red: x_val, green: 8'd0,  blue: s4_c};
      default: rgb_next = '{red: s4_c,  green: 8'd0,  blue: x_val};
    endcase
    rgb_next.red   = rgb_next.red + s4_m;
    rgb_next.green = rgb_next.green + s4_m;
    rgb_next.blue  = rgb_next.blue + s4_m;
  end

  // Delay the RGB result to line up with the dividers
  always_ff @(posedge clk) begin
    rgbd[0] <= rgb_next;
    for (int i = 1; i < RgbDepth; i++) begin
      rgbd[i] <= rgbd[i-1];
    end
  end

  // Add the sector offset to the hue fraction and wrap once
  always_comb begin
    hoff = {1'b0, side[SideDepth-1].sel, 9'd0};
    if (side[SideDepth-1].neg) begin
      hsum = hoff + {1'b0, HueTurn} - {3'd0, hue_quo};
    end else begin
      hsum = hoff + {3'd0, hue_quo};
    end
    hwrap = (hsum >= {1'b0, HueTurn}) ? (hsum - {1'b0, HueTurn}) : hsum;
  end

  // Drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_valid[SideDepth-1];
    end
  end

  always_ff @(posedge clk) begin
    alpha_out <= side[SideDepth-1].alpha;
    if (side[SideDepth-1].func) begin
      red_out   <= 8'd0;
      green_out <= 8'd0;
      blue_out  <= 8'd0;
      val_out   <= side[SideDepth-1].vmax;
      if (side[SideDepth-1].grey) begin
        hue_out <= 11'd0;
        sat_out <= 8'd0;
      end else begin
        hue_out <= hwrap[10:0];
        sat_out <= sat_quo[7:0];
      end
    end else begin
      red_out   <= rgbd[RgbDepth-1].red;
      green_out <= rgbd[RgbDepth-1].green;
      blue_out  <= rgbd[RgbDepth-1].blue;
      hue_out   <= 11'd0;
      sat_out   <= 8'd0;
      val_out   <= 8'd0;
    end
  end

endmodule

FILE: design/hsvc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module hsvc_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 8,
  parameter int Q_W   = 9
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  // The caller guarantees num < den * 2**Q_W, so the top bits start below den
  logic [DEN_W-1:0] rem  [Q_W-1];
  logic [DEN_W-1:0] dvs  [Q_W-1];
  logic [Q_W-1:0]   low  [Q_W-1];
  logic [Q_W-1:0]   qacc [Q_W];

  generate
    for (genvar i = 0; i < Q_W; i++) begin : g_step
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W-1:0] den_in;
      logic [Q_W-1:0]   low_in;
      logic [Q_W-1:0]   q_in;
      logic [DEN_W:0]   trial;
      logic             fits;

      // Pick the stage input: ports for the first step, previous stage after
      if (i == 0) begin : g_first
        assign rem_in = DEN_W'(num >> Q_W);
        assign low_in = num[Q_W-1:0];
        assign den_in = den;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem[i-1];
        assign low_in = low[i-1];
        assign den_in = dvs[i-1];
        assign q_in   = qacc[i-1];
      end

      // Shift in the next dividend bit and try the subtract
      assign trial = {rem_in, low_in[Q_W-1]};
      assign fits  = (trial >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        qacc[i] <= {q_in[Q_W-2:0], fits};
      end

      // Carry the partial remainder forward except out of the last step
      if (i < Q_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          rem[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
          low[i] <= {low_in[Q_W-2:0], 1'b0};
          dvs[i] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = qacc[Q_W-1];

endmodule

FILE: design/hsvc_check.sv
// Port-level checker for the HSV/RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsvc_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic [10:0] hue_out,
  input logic [7:0]  sat_out,
  input logic [7:0]  val_out,
  input logic [7:0]  alpha_in,
  input logic [7:0]  alpha_out
);

  import hsvc_pkg::*;

  // Never refuse a beat
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##PipeLatency done)
    else $error("result beat missing after latency");

  // Alpha of a result is the alpha of the beat that made it
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (alpha_out == $past(alpha_in, PipeLatency + 1)))
    else $error("alpha not carried through");

  // One direction's fields are zero on every result
  a_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> ((hue_out == 11'd0 && sat_out == 8'd0 && val_out == 8'd0) ||
              (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)))
    else $error("both result groups nonzero");

  // Hue stays inside one turn, and zero saturation means zero hue
  a_hue: assert property (@(posedge clk) disable iff (rst)
    done |-> ((hue_out < HueTurn) && (sat_out != 8'd0 || hue_out == 11'd0)))
    else $error("hue out of range");

endmodule

bind hsv_rgb_color_convert_top hsvc_check u_hsvc_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .hue_out   (hue_out),
  .sat_out   (sat_out),
  .val_out   (val_out),
  .alpha_in  (alpha_in),
  .alpha_out (alpha_out)
);

FILE: tb/sv/hsv_rgb_color_convert_top_tb.sv
// Self-checking testbench for the HSV/RGB pixel converter top level.
`timescale 1ns / 1ps

module hsv_rgb_color_convert_top_tb;
  import hsvc_pkg::*;

  // Conversion direction codes
  localparam logic FuncToRgb = 1'b0;
  localparam logic FuncToHsv = 1'b1;

  localparam int RandomPixels = 1850;
  localparam int CycleLimit   = 200000;
  localparam int DirectedRows = 25;

  typedef struct packed {
    logic        func;
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } pixel_result_t;

  // A known row carries its result typed in; the rest go through the predictor
  typedef struct packed {
    pixel_cmd_t    cmd;
    logic          known;
    pixel_result_t res;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = FuncToRgb;
  logic [10:0] hue_in = '0;
  logic [7:0]  sat_in = '0;
  logic [7:0]  val_in = '0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic [7:0]  alpha_in = '0;
  logic        done;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] hue_out;
  logic [7:0]  sat_out;
  logic [7:0]  val_out;
  logic [7:0]  alpha_out;

  pixel_result_t expected_pixels[$];
  int            errors = 0;
  int            cycle_count = 0;

  // Directed rows: extremes, primaries, hue wrap, ties, grey, unused fields
  pixel_row_t directed_rows [DirectedRows] = '{
    // HSV to RGB: black, white, primaries, yellow
    '{'{FuncToRgb, 11'd0,    8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd0, 8'd0, 8'd0, 8'h00}},
    '{'{FuncToRgb, 11'd0,    8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'hff}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 11'd0, 8'd0, 8'd0, 8'hff}},
    '{'{FuncToRgb, 11'd0,    8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'h80}, 1'b1,
      '{8'd255, 8'd0,   8'd0,   11'd0, 8'd0, 8'd0, 8'h80}},
    '{'{FuncToRgb, 11'd512,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'h01}, 1'b1,
      '{8'd0,   8'd255, 8'd0,   11'd0, 8'd0, 8'd0, 8'h01}},
    '{'{FuncToRgb, 11'd1024, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'h7f}, 1'b1,
      '{8'd0,   8'd0,   8'd255, 11'd0, 8'd0, 8'd0, 8'h7f}},
    '{'{FuncToRgb, 11'd256,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'h55}, 1'b1,
      '{8'd255, 8'd255, 8'd0,   11'd0, 8'd0, 8'd0, 8'h55}},
    // Top of the hue range, then out-of-range hue that wraps
    '{'{FuncToRgb, 11'd1535, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'haa}, 1'b0, '0},
    '{'{FuncToRgb, 11'd1536, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'h3c}, 1'b1,
      '{8'd255, 8'd0,   8'd0,   11'd0, 8'd0, 8'd0, 8'h3c}},
    '{'{FuncToRgb, 11'd2047, 8'd200, 8'd240, 8'd0,   8'd0,   8'd0,   8'hc3}, 1'b0, '0},
    // Full saturation with a tiny value, and a mid-range pixel
    '{'{FuncToRgb, 11'd100,  8'd255, 8'd1,   8'd0,   8'd0,   8'd0,   8'h10}, 1'b0, '0},
    '{'{FuncToRgb, 11'd1023, 8'd128, 8'd200, 8'd0,   8'd0,   8'd0,   8'h20}, 1'b0, '0},
    // RGB to HSV: black, white, grey
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd0, 8'd0, 8'd0, 8'h00}},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'hff}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd0, 8'd0, 8'd255, 8'hff}},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd77,  8'd77,  8'd77,  8'h44}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd0, 8'd0, 8'd77, 8'h44}},
    // Primaries
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'h11}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd0,    8'd255, 8'd255, 8'h11}},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'h22}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd512,  8'd255, 8'd255, 8'h22}},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'h33}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   11'd1024, 8'd255, 8'd255, 8'h33}},
    // Equal maxima: red over green, green over blue, red over blue
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'h66}, 1'b0, '0},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd10,  8'd200, 8'd200, 8'h77}, 1'b0, '0},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd180, 8'd20,  8'd180, 8'h88}, 1'b0, '0},
    // Negative hue that wraps (red max, blue over green), tiny red, blue max
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd255, 8'd0,   8'd10,  8'h99}, 1'b0, '0},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd1,   8'd0,   8'd0,   8'hee}, 1'b0, '0},
    '{'{FuncToHsv, 11'd0,    8'd0,   8'd0,   8'd12,  8'd200, 8'd255, 8'h5a}, 1'b0, '0},
    // Fields of the other direction set, to show unused outputs stay zero
    '{'{FuncToHsv, 11'd2047, 8'd255, 8'd255, 8'd100, 8'd50,  8'd25,  8'hf0}, 1'b0, '0},
    '{'{FuncToRgb, 11'd700,  8'd90,  8'd180, 8'd255, 8'd255, 8'd255, 8'h0f}, 1'b0, '0}
  };

  hsv_rgb_color_convert_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .hue_in    (hue_in),
    .sat_in    (sat_in),
    .val_in    (val_in),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out),
    .alpha_out (alpha_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hue from an offset plus the rounded signed fraction, wrapped into one turn
  function automatic logic [10:0] hue_from_offset(int unsigned offset, int unsigned p,
                                                  int unsigned q, int unsigned d);
    int unsigned h;
    if (p >= q) begin
      h = offset + ((p - q) * 256 + d / 2) / d;
    end else begin
      h = offset + HueTurn - ((q - p) * 256 + d / 2) / d;
    end
    while (h >= HueTurn) h -= HueTurn;
    return h[10:0];
  endfunction

  // Expected converter output for one pixel
  function automatic pixel_result_t convert_pixel(pixel_cmd_t cmd);
    pixel_result_t res;
    int unsigned   h, c, f, x, m, sector, rr, gg, bb, mx, mn, d;
    res = '0;
    res.alpha = cmd.alpha;
    if (cmd.func == FuncToRgb) begin
      h = cmd.hue;
      if (h >= HueTurn) h -= HueTurn;
      sector = h >> 8;
      f = h & 255;
      c = (cmd.val * cmd.sat + 127) / 255;
      x = (sector % 2 == 1) ? (c * (256 - f) + 128) >> 8 : (c * f + 128) >> 8;
      m = cmd.val - c;
      case (sector)
        0: begin rr = c; gg = x; bb = 0; end
        1: begin rr = x; gg = c; bb = 0; end
        2: begin rr = 0; gg = c; bb = x; end
        3: begin rr = 0; gg = x; bb = c; end
        4: begin rr = x; gg = 0; bb = c; end
        default: begin rr = c; gg = 0; bb = x; end
      endcase
      rr += m;
      gg += m;
      bb += m;
      res.red = rr[7:0];
      res.green = gg[7:0];
      res.blue = bb[7:0];
    end else begin
      mx = cmd.red;
      if (cmd.green > mx) mx = cmd.green;
      if (cmd.blue > mx) mx = cmd.blue;
      mn = cmd.red;
      if (cmd.green < mn) mn = cmd.green;
      if (cmd.blue < mn) mn = cmd.blue;
      d = mx - mn;
      res.val = mx[7:0];
      if (d > 0) begin
        if (mx == cmd.red) begin
          res.hue = hue_from_offset(0, cmd.green, cmd.blue, d);
        end else if (mx == cmd.green) begin
          res.hue = hue_from_offset(512, cmd.blue, cmd.red, d);
        end else begin
          res.hue = hue_from_offset(1024, cmd.red, cmd.green, d);
        end
        res.sat = 8'((d * 255 + mx / 2) / mx);
      end
    end
    return res;
  endfunction

  // Channel value biased toward the ends of the range
  function automatic logic [7:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_cmd_t rand_pixel();
    pixel_cmd_t cmd;
    cmd.func  = 1'($urandom_range(0, 1));
    // Mostly in-range hue, with a share of values that wrap
    cmd.hue   = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1536, 2047))
                                            : 11'($urandom_range(0, 1535));
    cmd.sat   = rand_channel();
    cmd.val   = rand_channel();
    cmd.red   = rand_channel();
    cmd.green = rand_channel();
    cmd.blue  = rand_channel();
    cmd.alpha = 8'($urandom_range(0, 255));
    // Force ties between channels now and then to hit max priority and grey
    case ($urandom_range(0, 9))
      0: cmd.green = cmd.red;
      1: cmd.blue = cmd.green;
      2: cmd.blue = cmd.red;
      3: begin cmd.green = cmd.red; cmd.blue = cmd.red; end
      default: ;
    endcase
    return cmd;
  endfunction

  // Present one beat and hold it until the converter takes it
  task automatic drive_pixel(pixel_cmd_t cmd, pixel_result_t res);
    @(negedge clk);
    start    <= 1'b1;
    func     <= cmd.func;
    hue_in   <= cmd.hue;
    sat_in   <= cmd.sat;
    val_in   <= cmd.val;
    red_in   <= cmd.red;
    green_in <= cmd.green;
    blue_in  <= cmd.blue;
    alpha_in <= cmd.alpha;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pixels.push_back(res);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Compare every done beat with the oldest expectation
  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("done: unexpected result beat");
        errors++;
      end else begin
        exp_res = expected_pixels.pop_front();
        check_field("red_out", exp_res.red, red_out);
        check_field("green_out", exp_res.green, green_out);
        check_field("blue_out", exp_res.blue, blue_out);
        check_field("hue_out", exp_res.hue, hue_out);
        check_field("sat_out", exp_res.sat, sat_out);
        check_field("val_out", exp_res.val, val_out);
        check_field("alpha_out", exp_res.alpha, alpha_out);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pixel_cmd_t cmd;
    int         sent;
    int         burst;
    bit         paused;
    sent = 0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, back to back
    foreach (directed_rows[i]) begin
      drive_pixel(directed_rows[i].cmd,
                  directed_rows[i].known ? directed_rows[i].res
                                         : convert_pixel(directed_rows[i].cmd));
    end
    wait_drained();

    // Random pixels in bursts with random gaps
    while (sent < RandomPixels) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RandomPixels; i++) begin
        cmd = rand_pixel();
        drive_pixel(cmd, convert_pixel(cmd));
        sent++;
      end
      if (!paused && sent >= RandomPixels / 2) begin
        wait_drained();
        paused = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (PipeLatency + 4) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("done: %0d results never arrived", expected_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/hsvc_pkg.sv
design/hsvc_div.sv
design/hsv_rgb_color_convert_top.sv
design/hsvc_check.sv
tb/sv/hsv_rgb_color_convert_top_tb.sv
